/* hw/rtl/bce_pkg.sv */
// Shared types, constants and helper functions for the BCD calendar to epoch converter.
package bce_pkg;

    localparam int unsigned SecsPerDay  = 86400;
    localparam int unsigned SecsPerHour = 3600;
    localparam int unsigned SecsPerMin  = 60;
    localparam int unsigned DaysPerYear = 365;
    // 2000 - 1970: whole years from the epoch to the start of the century
    localparam int unsigned CenturyYears = 30;

    localparam logic [7:0] SecMask   = 8'h7F;
    localparam logic [7:0] MinMask   = 8'h7F;
    localparam logic [7:0] HourMask  = 8'h3F;
    localparam logic [7:0] DateMask  = 8'h3F;
    localparam logic [7:0] MonthMask = 8'h1F;

    localparam logic [3:0] MonthJan = 4'd1;
    localparam logic [3:0] MonthFeb = 4'd2;
    localparam logic [3:0] MonthDec = 4'd12;

    // Decoded calendar fields, after stage 1
    typedef struct packed {
        logic [6:0] sec;
        logic [6:0] min;
        logic [5:0] hour;
        logic [5:0] mday;
        logic [3:0] month;
        logic [7:0] year;
        logic       bad_month;
    } dec_fields_t;

    // Day count and seconds within the day, after stage 2
    typedef struct packed {
        logic [16:0]        days;
        logic signed [18:0] subday;
        logic               bad_month;
    } day_fields_t;

    // Face-value BCD decode: high nibble * 10 + low nibble
    function automatic logic [7:0] bcd_decode(input logic [7:0] b);
        bcd_decode = {1'b0, b[7:4], 3'b000} + {3'b000, b[7:4], 1'b0} + {4'b0000, b[3:0]};
    endfunction

    // Days before the first of each month in a common year
    function automatic logic [8:0] days_before_month(input logic [3:0] m);
        unique case (m)
            4'd1:    days_before_month = 9'd0;
            4'd2:    days_before_month = 9'd31;
            4'd3:    days_before_month = 9'd59;
            4'd4:    days_before_month = 9'd90;
            4'd5:    days_before_month = 9'd120;
            4'd6:    days_before_month = 9'd151;
            4'd7:    days_before_month = 9'd181;
            4'd8:    days_before_month = 9'd212;
            4'd9:    days_before_month = 9'd243;
            4'd10:   days_before_month = 9'd273;
            4'd11:   days_before_month = 9'd304;
            4'd12:   days_before_month = 9'd334;
            default: days_before_month = 9'd0;
        endcase
    endfunction

endpackage

/* hw/rtl/bce_decode.sv */
// Stage 1: masks the raw register bytes (all but the year), decodes BCD and checks the month.
module bce_decode (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [47:0]          in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output bce_pkg::dec_fields_t out_data
);

    logic                 valid_reg;
    logic                 valid_next;
    bce_pkg::dec_fields_t data_reg;
    bce_pkg::dec_fields_t data_next;
    logic [7:0]           sec_dec;
    logic [7:0]           min_dec;
    logic [7:0]           hour_dec;
    logic [7:0]           mday_dec;
    logic [7:0]           month_dec;
    logic [7:0]           year_dec;
    logic                 bad;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_comb begin
        sec_dec   = bce_pkg::bcd_decode(in_data[7:0]   & bce_pkg::SecMask);
        min_dec   = bce_pkg::bcd_decode(in_data[15:8]  & bce_pkg::MinMask);
        hour_dec  = bce_pkg::bcd_decode(in_data[23:16] & bce_pkg::HourMask);
        mday_dec  = bce_pkg::bcd_decode(in_data[31:24] & bce_pkg::DateMask);
        month_dec = bce_pkg::bcd_decode(in_data[39:32] & bce_pkg::MonthMask);
        year_dec  = bce_pkg::bcd_decode(in_data[47:40]);
        bad = (month_dec < 8'(bce_pkg::MonthJan)) || (month_dec > 8'(bce_pkg::MonthDec));

        data_next.sec       = sec_dec[6:0];
        data_next.min       = min_dec[6:0];
        data_next.hour      = hour_dec[5:0];
        data_next.mday      = mday_dec[5:0];
        data_next.month     = bad ? bce_pkg::MonthJan : month_dec[3:0];
        data_next.year      = year_dec;
        data_next.bad_month = bad;

        valid_next = in_ready ? in_valid : valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            data_reg <= data_next;
        end
    end

endmodule

/* hw/rtl/bce_days.sv */
// Stage 2: day count since the epoch and offset-adjusted seconds within the day.
module bce_days (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic [4:0]           utc_offset,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  bce_pkg::dec_fields_t in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output bce_pkg::day_fields_t out_data
);

    logic                 valid_reg;
    logic                 valid_next;
    bce_pkg::day_fields_t data_reg;
    bce_pkg::day_fields_t data_next;
    logic [7:0]           years;
    logic [16:0]          years_days;
    logic [5:0]           leaps;
    logic                 leap_now;
    logic signed [6:0]    hour_adj;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_comb begin
        years      = in_data.year + 8'(bce_pkg::CenturyYears);
        years_days = 17'(years) * 17'(bce_pkg::DaysPerYear);
        // leap days in the years before this one
        leaps      = 6'((9'(years) + 9'd1) >> 2);
        // this year's leap day, once February is over
        leap_now   = (in_data.year[1:0] == 2'b00) && (in_data.month > bce_pkg::MonthFeb);

        data_next.days = years_days + 17'(leaps) + 17'(leap_now)
                       + 17'(bce_pkg::days_before_month(in_data.month))
                       + 17'(in_data.mday) - 17'd1;

        hour_adj = $signed({1'b0, in_data.hour}) + $signed({{2{utc_offset[4]}}, utc_offset});
        data_next.subday = 19'(hour_adj) * 19'sd3600
                         + $signed({12'd0, in_data.min}) * 19'sd60
                         + $signed({12'd0, in_data.sec});
        data_next.bad_month = in_data.bad_month;

        valid_next = in_ready ? in_valid : valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            data_reg <= data_next;
        end
    end

endmodule

/* hw/rtl/bce_sum.sv */
// Stage 3: scales days to seconds, adds the time of day, holds the output register.
module bce_sum (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  bce_pkg::day_fields_t in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [31:0]          out_seconds,
    output logic                 out_bad_month
);

    logic        valid_reg;
    logic        valid_next;
    logic [31:0] seconds_reg;
    logic [31:0] seconds_next;
    logic        bad_reg;
    logic [33:0] day_secs;

    assign in_ready      = !valid_reg || out_ready;
    assign out_valid     = valid_reg;
    assign out_seconds   = seconds_reg;
    assign out_bad_month = bad_reg;

    always_comb begin
        day_secs     = 34'(in_data.days) * 34'(bce_pkg::SecsPerDay);
        // total wraps modulo 2^32; a negative time of day borrows from the days
        seconds_next = day_secs[31:0] + 32'(in_data.subday);
        valid_next   = in_ready ? in_valid : valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            seconds_reg <= seconds_next;
            bad_reg     <= in_data.bad_month;
        end
    end

endmodule

/* hw/rtl/bcd_calendar_to_epoch_seconds.sv */
// BCD calendar to epoch seconds: top level, three-stage pipeline.
//
// Input stream (s_*): one request carries the six raw RTC calendar bytes
// in s_tdata. Each but the year is masked, all are BCD-decoded; the year means 20xx.
// Output stream (m_*): seconds since 1970-01-01 00:00 in m_tdata, modulo
// 2^32, with m_tuser high when the month byte decodes outside 1..12 (the
// month is then taken as January).
// Config channel (cfg_*): writes the signed hour offset added to the clock
// hour. cfg_ready is always high; write it only while no request is in
// flight.
// Stages: decode, day count, seconds scaling; one register each.
// Throughput: one request per cycle while m_tready is high; every stage
// has its own valid bit, and a stage loads whenever it is empty or the next one takes its contents.
// Stall: when m_tready is low the pipeline fills up and s_tready drops once
// all three stages hold a request; nothing is lost or repeated.
// Reset (aresetn low, synchronous): all stages empty, offset back to 0.
module bcd_calendar_to_epoch_seconds (
    input  logic        aclk,
    input  logic        aresetn,
    // Input request
    input  logic        s_tvalid,
    output logic        s_tready,
    // [7:0] second_bcd, [15:8] minute_bcd, [23:16] hour_bcd,
    // [31:24] date_bcd, [39:32] month_bcd, [47:40] year_bcd
    input  logic [47:0] s_tdata,
    // Result
    output logic        m_tvalid,
    input  logic        m_tready,
    // [31:0] epoch_seconds
    output logic [31:0] m_tdata,
    // [0] bad_month
    output logic        m_tuser,
    // Config: utc_offset_hours, signed
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [4:0]  cfg_data
);

    logic                 cfg_write;
    logic [4:0]           utc_offset_reg;
    logic [4:0]           utc_offset_next;

    logic                 dec_valid;
    logic                 dec_ready;
    bce_pkg::dec_fields_t dec_data;
    logic                 day_valid;
    logic                 day_ready;
    bce_pkg::day_fields_t day_data;

    assign cfg_ready       = 1'b1;
    assign cfg_write       = cfg_valid && cfg_ready;
    assign utc_offset_next = cfg_write ? cfg_data : utc_offset_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            utc_offset_reg <= 5'd0;
        end else begin
            utc_offset_reg <= utc_offset_next;
        end
    end

    // Stage 1: mask and BCD decode
    bce_decode u_decode (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_data   (s_tdata),
        .out_valid (dec_valid),
        .out_ready (dec_ready),
        .out_data  (dec_data)
    );

    // Stage 2: day count and time of day
    bce_days u_days (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .utc_offset (utc_offset_reg),
        .in_valid   (dec_valid),
        .in_ready   (dec_ready),
        .in_data    (dec_data),
        .out_valid  (day_valid),
        .out_ready  (day_ready),
        .out_data   (day_data)
    );

    // Stage 3: total seconds, output register
    bce_sum u_sum (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .in_valid      (day_valid),
        .in_ready      (day_ready),
        .in_data       (day_data),
        .out_valid     (m_tvalid),
        .out_ready     (m_tready),
        .out_seconds   (m_tdata),
        .out_bad_month (m_tuser)
    );

    // Input back-pressure only ever comes from a stalled, full pipeline
    a_stall_only_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (m_tvalid && !m_tready && day_valid && dec_valid))
        else $error("input stalled while pipeline not full");

    // With the receiver held ready, an accepted request reaches the output
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && m_tready) ##1 m_tready ##1 m_tready |=> m_tvalid)
        else $error("request did not reach output in three cycles");

    // Reset empties the pipeline
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> (!m_tvalid && !day_valid && !dec_valid))
        else $error("pipeline not empty after reset");

endmodule

/* sim/bcd_calendar_to_epoch_seconds_tb.sv */
// Self-checking testbench for the BCD calendar to epoch seconds converter.
`timescale 1ns / 1ps

module bcd_calendar_to_epoch_seconds_tb;

    // Raw calendar bytes as they travel in s_tdata: second in the low byte.
    typedef struct packed {
        logic [7:0] year;
        logic [7:0] month;
        logic [7:0] date;
        logic [7:0] hour;
        logic [7:0] minute;
        logic [7:0] second;
    } rtc_regs_t;

    typedef struct packed {
        logic [31:0] secs;
        logic        bad_month;
    } epoch_result_t;

    localparam int StallLimit = 5000;   // cycles with no handshake at all
    localparam int ChokeCycles = 300;   // long receiver hold-off
    localparam int MaxReported = 10;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;         // second, minute, hour, date, month, year (low to high)
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;              // [31:0] epoch_seconds
    logic        m_tuser;              // [0] bad_month
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [4:0]  cfg_data = '0;

    // Cumulative day count at the first of each month, common year
    int month_start_day [12] = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};

    rtc_regs_t         pending_regs[$];    // requests not yet offered
    epoch_result_t     expected_epochs[$]; // predictions waiting for their result
    logic signed [4:0] tz_offset;          // predictor's copy of the hour offset
    logic signed [4:0] cfg_hours = '0;     // offset the next config write carries
    int                cfg_issue_cnt = 0;
    int                cfg_done_cnt = 0;
    int                queued_cnt = 0;
    int                checked_cnt = 0;
    int                mismatch_cnt = 0;
    int                src_gap = 0;
    int                sink_hold = 0;
    int                choke_left = 0;
    bit                choke_req = 1'b0;
    bit                choke_done = 1'b0;
    bit                no_idle = 1'b0;
    int                quiet_cycles = 0;

    bcd_calendar_to_epoch_seconds uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Nibbles taken at face value, so 0xFF reads as 165.
    function automatic int bcd_face(input logic [7:0] b);
        return int'(b[7:4]) * 10 + int'(b[3:0]);
    endfunction

    function automatic logic [7:0] to_bcd(input int n);
        return {4'(n / 10), 4'(n % 10)};
    endfunction

    // Expected epoch seconds for one set of calendar bytes.
    function automatic epoch_result_t epoch_of(input rtc_regs_t r, input logic signed [4:0] offs);
        int            sec, mins, hr, mday, mon, yr, hr_shift;
        longint        years, leaps, days, total;
        epoch_result_t res;
        sec  = bcd_face(r.second & bce_pkg::SecMask);
        mins = bcd_face(r.minute & bce_pkg::MinMask);
        hr   = bcd_face(r.hour & bce_pkg::HourMask);
        mday = bcd_face(r.date & bce_pkg::DateMask);
        mon  = bcd_face(r.month & bce_pkg::MonthMask);
        yr   = bcd_face(r.year);
        hr_shift = offs;
        res.bad_month = (mon < 1 || mon > 12);
        if (res.bad_month) mon = 1;
        years = bce_pkg::CenturyYears + yr;
        // leap days of the years already over, every fourth year from 1972
        leaps = (years + 1) / 4;
        // this year's leap day only once February is past
        if (((years + 2) % 4) == 0 && mon > 2) leaps++;
        // date 0 and oversized dates run linearly into the neighbor months
        days = years * bce_pkg::DaysPerYear + leaps + month_start_day[mon - 1] + (mday - 1);
        total = days * bce_pkg::SecsPerDay + longint'(hr + hr_shift) * bce_pkg::SecsPerHour
              + longint'(mins) * bce_pkg::SecsPerMin + sec;
        res.secs = total[31:0];
        return res;
    endfunction

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (no_idle || roll < 60) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        if (roll < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [7:0] stray_bits(input logic [7:0] mask);
        return ($urandom_range(0, 3) == 0) ? (8'($urandom) & ~mask) : 8'h00;
    endfunction

    task automatic log_mismatch(input string detail);
        mismatch_cnt++;
        if (mismatch_cnt <= MaxReported)
            $display("[%0t] mismatch: %s", $realtime, detail);
    endtask

    // Driver: one request at a time from pending_regs, with random gaps.
    // The prediction is made at the very edge where the request is taken.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready)
                expected_epochs.push_back(epoch_of(rtc_regs_t'(s_tdata), tz_offset));
            if (!s_tvalid || s_tready) begin
                if (src_gap > 0) begin
                    src_gap--;
                    s_tvalid <= 1'b0;
                end else if (pending_regs.size() != 0) begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= pending_regs.pop_front();
                    src_gap = pick_gap();
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each result against the oldest prediction and
    // throttles m_tready; a one-time long hold-off backs the pipe up.
    always @(posedge aclk) begin
        epoch_result_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_epochs.size() == 0) begin
                    log_mismatch($sformatf("result %0d with no request pending", m_tdata));
                end else begin
                    want = expected_epochs.pop_front();
                    checked_cnt++;
                    if (m_tdata !== want.secs)
                        log_mismatch($sformatf("epoch_seconds expected %0d, got %0d",
                                               want.secs, m_tdata));
                    if (m_tuser !== want.bad_month)
                        log_mismatch($sformatf("bad_month expected %0b, got %0b",
                                               want.bad_month, m_tuser));
                end
            end
            if (choke_req && !choke_done) begin
                choke_left = ChokeCycles;
                choke_done = 1'b1;
            end
            if (choke_left > 0) begin
                choke_left--;
                m_tready <= 1'b0;
            end else if (sink_hold > 0) begin
                sink_hold--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                sink_hold = pick_gap();
            end
        end
    end

    // Config channel: drives each requested write; the predictor picks up
    // the offset on the same handshake.
    always @(posedge aclk) begin
        if (!aresetn) begin
            tz_offset = '0;
            cfg_valid <= 1'b0;
        end else if (cfg_valid && cfg_ready) begin
            tz_offset = cfg_data;
            cfg_valid <= 1'b0;
            cfg_done_cnt++;
        end else if (!cfg_valid && cfg_issue_cnt != cfg_done_cnt) begin
            cfg_data  <= cfg_hours;
            cfg_valid <= 1'b1;
        end
    end

    // Watchdog: any handshake on any channel counts as progress.
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= StallLimit) begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    task automatic queue_cal(input logic [7:0] sec, input logic [7:0] mins, input logic [7:0] hr,
                             input logic [7:0] dt, input logic [7:0] mon, input logic [7:0] yr);
        pending_regs.push_back('{year: yr, month: mon, date: dt, hour: hr,
                                 minute: mins, second: sec});
        queued_cnt++;
    endtask

    // Mostly well-formed dates with stray masked bits, the rest raw noise.
    task automatic queue_random(input int n);
        rtc_regs_t   r;
        logic [63:0] raw;
        repeat (n) begin
            if ($urandom_range(0, 9) < 7) begin
                r.second = to_bcd($urandom_range(0, 59)) | stray_bits(bce_pkg::SecMask);
                r.minute = to_bcd($urandom_range(0, 59)) | stray_bits(bce_pkg::MinMask);
                r.hour   = to_bcd($urandom_range(0, 23)) | stray_bits(bce_pkg::HourMask);
                r.date   = to_bcd($urandom_range(1, 31)) | stray_bits(bce_pkg::DateMask);
                r.month  = to_bcd($urandom_range(1, 12)) | stray_bits(bce_pkg::MonthMask);
                r.year   = to_bcd($urandom_range(0, 99));
            end else begin
                raw = {$urandom, $urandom};
                r = raw[47:0];
            end
            pending_regs.push_back(r);
            queued_cnt++;
        end
    endtask

    // Every queued request has come back and been checked.
    task automatic wait_drained();
        do @(posedge aclk);
        while (checked_cnt != queued_cnt);
    endtask

    task automatic write_offset(input logic signed [4:0] hours);
        wait_drained();
        cfg_hours = hours;
        cfg_issue_cnt++;
        do @(posedge aclk);
        while (cfg_done_cnt != cfg_issue_cnt);
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed requests at the reset offset of zero
        queue_cal(8'h00, 8'h00, 8'h00, 8'h01, 8'h01, 8'h00);   // 2000-01-01 midnight
        queue_cal(8'h59, 8'h59, 8'h23, 8'h31, 8'h12, 8'h99);   // last second of 2099
        queue_cal(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);   // every bit set
        queue_cal(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);   // month 0 and date 0
        queue_cal(8'h30, 8'h15, 8'h12, 8'h15, 8'h13, 8'h24);   // month 13
        queue_cal(8'h00, 8'h00, 8'h00, 8'h01, 8'h1F, 8'h24);   // month decodes to 25
        queue_cal(8'h00, 8'h00, 8'h00, 8'h01, 8'h0D, 8'h24);   // bad digit, 13
        queue_cal(8'h00, 8'h00, 8'h00, 8'h01, 8'h0A, 8'h24);   // bad digit, still 10
        queue_cal(8'h00, 8'h00, 8'h00, 8'h01, 8'hE9, 8'h24);   // masked bits above month
        queue_cal(8'h59, 8'h59, 8'h23, 8'h28, 8'h02, 8'h24);   // leap year, Feb 28
        queue_cal(8'h00, 8'h00, 8'h00, 8'h29, 8'h02, 8'h24);   // leap day itself
        queue_cal(8'h00, 8'h00, 8'h00, 8'h01, 8'h03, 8'h24);   // first day after leap day
        queue_cal(8'h00, 8'h00, 8'h00, 8'h01, 8'h03, 8'h23);   // common year, Mar 1
        queue_cal(8'h00, 8'h00, 8'h00, 8'h01, 8'h03, 8'h00);   // 2000 counts as leap
        queue_cal(8'h00, 8'h00, 8'h00, 8'h00, 8'h03, 8'h24);   // date 0 falls back a month
        queue_cal(8'h00, 8'h00, 8'h00, 8'h3F, 8'h01, 8'h24);   // date 45 runs on
        queue_cal(8'h00, 8'h00, 8'h00, 8'hC1, 8'h01, 8'h24);   // masked bits above date
        queue_cal(8'h7F, 8'h7F, 8'h3F, 8'h01, 8'h01, 8'h24);   // sec/min/hour at mask top
        queue_cal(8'h9A, 8'hAF, 8'h9F, 8'h9F, 8'h09, 8'h9F);   // face-value nibbles
        queue_cal(8'h00, 8'h00, 8'h00, 8'h01, 8'h01, 8'hA0);   // year 2100, no century rule
        // year byte A6 reads as 106; 2100 counted as leap moves the limit a day
        queue_cal(8'h15, 8'h28, 8'h06, 8'h06, 8'h02, 8'hA6);   // last 32-bit second
        queue_cal(8'h16, 8'h28, 8'h06, 8'h06, 8'h02, 8'hA6);   // wraps to zero
        queue_cal(8'h80, 8'h80, 8'hC0, 8'h01, 8'hE1, 8'h70);   // only masked bits set in second, minute and hour

        write_offset(-5'sd12);
        queue_random(120);

        write_offset(5'sd14);
        queue_cal(8'h59, 8'h59, 8'h23, 8'h31, 8'h12, 8'h99);   // hour pushed past 23
        queue_random(120);

        // Most negative pattern: hour goes below zero
        write_offset(-5'sd16);
        queue_cal(8'h00, 8'h00, 8'h00, 8'h01, 8'h01, 8'h00);
        queue_random(120);

        write_offset(5'sd15);
        queue_random(120);

        // Back-to-back stretch with no idling on either side
        write_offset(5'sd0);
        no_idle = 1'b1;
        queue_random(120);
        wait_drained();

        // Receiver holds off for a long time while requests keep coming
        write_offset(-5'sd3);
        queue_random(100);
        choke_req = 1'b1;
        wait_drained();
        no_idle = 1'b0;

        repeat (3) begin
            write_offset(5'($urandom_range(0, 31)));
            queue_random(110);
        end

        wait_drained();
        repeat (10) @(posedge aclk);
        if (mismatch_cnt == 0 && expected_epochs.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
